>>> sv/rk4_pkg.sv
`default_nettype none
package rk4_pkg;

    // Q16.47 fixed point
    localparam int FRAC_BITS = 47;

    localparam logic [63:0] SIX_Q    = 64'(6) << FRAC_BITS;
    localparam logic [62:0] GM_RESET = 63'd41654600000;
    localparam logic [62:0] DT_RESET = 63'd1628900000000;

    // micro-operations
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_SQRT = 3'd4;
    localparam logic [2:0] OP_JMP  = 3'd5;
    localparam logic [2:0] OP_LOOP = 3'd6;
    localparam logic [2:0] OP_END  = 3'd7;

    // jump conditions
    localparam logic [1:0] C_ALWAYS = 2'd0;
    localparam logic [1:0] C_FIRST  = 2'd1;
    localparam logic [1:0] C_LAST   = 2'd2;

    // operand codes: below 16 are registers and constants, 16 and up scratch RAM
    localparam logic [4:0] R_PX   = 5'd0;
    localparam logic [4:0] R_PY   = 5'd1;
    localparam logic [4:0] R_VX   = 5'd2;
    localparam logic [4:0] R_VY   = 5'd3;
    localparam logic [4:0] R_SX   = 5'd4;
    localparam logic [4:0] R_SY   = 5'd5;
    localparam logic [4:0] R_GM   = 5'd6;
    localparam logic [4:0] R_DT   = 5'd7;
    localparam logic [4:0] R_H    = 5'd8;
    localparam logic [4:0] R_SIX  = 5'd9;
    localparam logic [4:0] R_ZERO = 5'd10;
    localparam logic [4:0] R_STEP = 5'd11;
    localparam logic [4:0] M_CX   = 5'd16;
    localparam logic [4:0] M_CY   = 5'd17;
    localparam logic [4:0] M_NVX  = 5'd18;
    localparam logic [4:0] M_NVY  = 5'd19;
    localparam logic [4:0] M_AX   = 5'd20;
    localparam logic [4:0] M_AY   = 5'd21;
    localparam logic [4:0] M_DX   = 5'd22;
    localparam logic [4:0] M_DY   = 5'd23;
    localparam logic [4:0] M_R2   = 5'd24;
    localparam logic [4:0] M_T    = 5'd25;
    localparam logic [4:0] M_R3   = 5'd26;
    localparam logic [4:0] M_SVX  = 5'd27;
    localparam logic [4:0] M_SVY  = 5'd28;
    localparam logic [4:0] M_SAX  = 5'd29;
    localparam logic [4:0] M_SAY  = 5'd30;
    localparam logic [4:0] M_T2   = 5'd31;

    localparam logic [5:0] L_LOOP  = 6'd4;
    localparam logic [5:0] L_FIRST = 6'd26;
    localparam logic [5:0] L_NEXT  = 6'd31;
    localparam logic [5:0] L_LAST  = 6'd40;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] dst;
        logic [4:0] srca;
        logic [4:0] srcb;
        logic [1:0] cond;
        logic [5:0] target;
    } t_uword;

    function automatic t_uword uw(input logic [2:0] op, input logic [4:0] dst,
                                  input logic [4:0] a, input logic [4:0] b,
                                  input logic [1:0] cond, input logic [5:0] tgt);
        t_uword w;
        w.op     = op;
        w.dst    = dst;
        w.srca   = a;
        w.srcb   = b;
        w.cond   = cond;
        w.target = tgt;
        return w;
    endfunction

    function automatic t_uword alu(input logic [2:0] op, input logic [4:0] dst,
                                   input logic [4:0] a, input logic [4:0] b);
        return uw(op, dst, a, b, C_ALWAYS, 6'd0);
    endfunction

    // RK4 step program
    function automatic t_uword ucode(input logic [5:0] pc);
        t_uword w;
        case (pc)
            6'd0:  w = alu(OP_ADD, M_CX, R_PX, R_ZERO);
            6'd1:  w = alu(OP_ADD, M_CY, R_PY, R_ZERO);
            6'd2:  w = alu(OP_ADD, M_NVX, R_VX, R_ZERO);
            6'd3:  w = alu(OP_ADD, M_NVY, R_VY, R_ZERO);
            // acceleration at (CX, CY)
            6'd4:  w = alu(OP_SUB, M_DX, R_SX, M_CX);
            6'd5:  w = alu(OP_SUB, M_DY, R_SY, M_CY);
            6'd6:  w = alu(OP_MUL, M_R2, M_DX, M_DX);
            6'd7:  w = alu(OP_MUL, M_T, M_DY, M_DY);
            6'd8:  w = alu(OP_ADD, M_R2, M_R2, M_T);
            6'd9:  w = alu(OP_SQRT, M_T, M_R2, R_ZERO);
            6'd10: w = alu(OP_MUL, M_R3, M_R2, M_T);
            6'd11: w = alu(OP_MUL, M_T, R_GM, M_DX);
            6'd12: w = alu(OP_DIV, M_AX, M_T, M_R3);
            6'd13: w = alu(OP_MUL, M_T, R_GM, M_DY);
            6'd14: w = alu(OP_DIV, M_AY, M_T, M_R3);
            6'd15: w = uw(OP_JMP, R_ZERO, R_ZERO, R_ZERO, C_FIRST, L_FIRST);
            6'd16: w = uw(OP_JMP, R_ZERO, R_ZERO, R_ZERO, C_LAST, L_LAST);
            // middle stages: sum += 2k
            6'd17: w = alu(OP_ADD, M_T2, M_NVX, M_NVX);
            6'd18: w = alu(OP_ADD, M_SVX, M_SVX, M_T2);
            6'd19: w = alu(OP_ADD, M_T2, M_NVY, M_NVY);
            6'd20: w = alu(OP_ADD, M_SVY, M_SVY, M_T2);
            6'd21: w = alu(OP_ADD, M_T2, M_AX, M_AX);
            6'd22: w = alu(OP_ADD, M_SAX, M_SAX, M_T2);
            6'd23: w = alu(OP_ADD, M_T2, M_AY, M_AY);
            6'd24: w = alu(OP_ADD, M_SAY, M_SAY, M_T2);
            6'd25: w = uw(OP_JMP, R_ZERO, R_ZERO, R_ZERO, C_ALWAYS, L_NEXT);
            // first stage: sum = k
            6'd26: w = alu(OP_ADD, M_SVX, M_NVX, R_ZERO);
            6'd27: w = alu(OP_ADD, M_SVY, M_NVY, R_ZERO);
            6'd28: w = alu(OP_ADD, M_SAX, M_AX, R_ZERO);
            6'd29: w = alu(OP_ADD, M_SAY, M_AY, R_ZERO);
            6'd30: w = uw(OP_JMP, R_ZERO, R_ZERO, R_ZERO, C_ALWAYS, L_NEXT);
            // probe point for the next stage
            6'd31: w = alu(OP_MUL, M_T, R_STEP, M_NVX);
            6'd32: w = alu(OP_ADD, M_CX, R_PX, M_T);
            6'd33: w = alu(OP_MUL, M_T, R_STEP, M_NVY);
            6'd34: w = alu(OP_ADD, M_CY, R_PY, M_T);
            6'd35: w = alu(OP_MUL, M_T, R_STEP, M_AX);
            6'd36: w = alu(OP_ADD, M_NVX, R_VX, M_T);
            6'd37: w = alu(OP_MUL, M_T, R_STEP, M_AY);
            6'd38: w = alu(OP_ADD, M_NVY, R_VY, M_T);
            6'd39: w = uw(OP_LOOP, R_ZERO, R_ZERO, R_ZERO, C_ALWAYS, L_LOOP);
            // last stage: sum += k, then update state
            6'd40: w = alu(OP_ADD, M_SVX, M_SVX, M_NVX);
            6'd41: w = alu(OP_ADD, M_SVY, M_SVY, M_NVY);
            6'd42: w = alu(OP_ADD, M_SAX, M_SAX, M_AX);
            6'd43: w = alu(OP_ADD, M_SAY, M_SAY, M_AY);
            6'd44: w = alu(OP_MUL, M_T, R_DT, M_SVX);
            6'd45: w = alu(OP_DIV, M_T, M_T, R_SIX);
            6'd46: w = alu(OP_ADD, R_PX, R_PX, M_T);
            6'd47: w = alu(OP_MUL, M_T, R_DT, M_SVY);
            6'd48: w = alu(OP_DIV, M_T, M_T, R_SIX);
            6'd49: w = alu(OP_ADD, R_PY, R_PY, M_T);
            6'd50: w = alu(OP_MUL, M_T, R_DT, M_SAX);
            6'd51: w = alu(OP_DIV, M_T, M_T, R_SIX);
            6'd52: w = alu(OP_ADD, R_VX, R_VX, M_T);
            6'd53: w = alu(OP_MUL, M_T, R_DT, M_SAY);
            6'd54: w = alu(OP_DIV, M_T, M_T, R_SIX);
            6'd55: w = alu(OP_ADD, R_VY, R_VY, M_T);
            default: w = uw(OP_END, R_ZERO, R_ZERO, R_ZERO, C_ALWAYS, 6'd0);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

>>> sv/rk4_fxu.sv
`default_nettype none
// Fixed-point unit: saturating add/sub, multiply from four 32x32 partial
// products, bit-serial divide and square root
// (64 iterations).
module rk4_fxu (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [2:0]           i_op,
    input  wire logic [63:0]          i_a,
    input  wire logic [63:0]          i_b,
    output logic                      o_done,
    output logic [63:0]               o_result
);
    import rk4_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] S64_MIN = {1'b1, 63'd0};

    logic [1:0]   r_state;
    logic [2:0]   r_op;
    logic [6:0]   r_cnt;
    logic         r_neg;
    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic [127:0] r_acc;
    logic [66:0]  r_rem;
    logic [63:0]  r_q;
    logic         r_done;
    logic [63:0]  r_res;

    function automatic logic [63:0] sat_mag(input logic [63:0] m, input logic neg);
        logic [63:0] v;
        if (neg) begin
            v = m[63] ? S64_MIN : (64'd0 - m);
        end else begin
            v = m[63] ? S64_MAX : m;
        end
        return v;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        logic [63:0] v;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            v = s[64] ? S64_MIN : S64_MAX;
        end else begin
            v = s[63:0];
        end
        return v;
    endfunction

    logic [63:0]  ma, mb, nb, hi_a;
    logic         sgn;
    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [64:0]  drem;
    logic [66:0]  srem, strial;
    logic [128:0] mrnd;
    logic [63:0]  dleft;

    always_comb begin
        ma    = i_a[63] ? (64'd0 - i_a) : i_a;
        mb    = i_b[63] ? (64'd0 - i_b) : i_b;
        nb    = 64'd0 - i_b;
        sgn   = i_a[63] ^ i_b[63];
        hi_a  = ma >> (64 - FRAC_BITS);
        pa    = r_cnt[0] ? r_ma[63:32] : r_ma[31:0];
        pb    = r_cnt[1] ? r_mb[63:32] : r_mb[31:0];
        pp    = 64'(pa) * 64'(pb);
        case ({1'b0, r_cnt[0]} + {1'b0, r_cnt[1]})
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
        drem   = {r_rem[63:0], r_acc[63]};
        srem   = {r_rem[64:0], r_acc[127:126]};
        strial = {1'b0, r_q, 2'b01};
        mrnd   = {1'b0, r_acc} + (129'd1 << (FRAC_BITS - 1));
        dleft  = r_mb - r_rem[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op  <= i_op;
                        r_cnt <= 7'd0;
                        r_neg <= sgn;
                        r_ma  <= ma;
                        r_mb  <= mb;
                        r_q   <= 64'd0;
                        r_rem <= 67'd0;
                        case (i_op)
                            OP_ADD: begin
                                r_res  <= sat_add(i_a, i_b);
                                r_done <= 1'b1;
                            end
                            OP_SUB: begin
                                // a - b, with b = MIN handled apart, since its negation does not fit
                                if (i_b == S64_MIN) begin
                                    r_res <= i_a[63] ? (i_a ^ S64_MIN) : S64_MAX;
                                end else begin
                                    r_res <= sat_add(i_a, nb);
                                end
                                r_done <= 1'b1;
                            end
                            OP_MUL: begin
                                r_acc   <= 128'd0;
                                r_state <= S_RUN;
                            end
                            OP_DIV: begin
                                if (ma == 64'd0) begin
                                    r_res  <= 64'd0;
                                    r_done <= 1'b1;
                                end else if (mb == 64'd0) begin
                                    r_res  <= i_a[63] ? S64_MIN : S64_MAX;
                                    r_done <= 1'b1;
                                end else if (hi_a >= mb) begin
                                    r_res  <= sgn ? S64_MIN : S64_MAX;
                                    r_done <= 1'b1;
                                end else begin
                                    r_rem   <= {3'd0, hi_a};
                                    r_acc   <= {64'd0, ma << FRAC_BITS};
                                    r_state <= S_RUN;
                                end
                            end
                            OP_SQRT: begin
                                if (i_a[63] || i_a == 64'd0) begin
                                    r_res  <= 64'd0;
                                    r_done <= 1'b1;
                                end else begin
                                    r_acc   <= {64'd0, i_a} << FRAC_BITS;
                                    r_state <= S_RUN;
                                end
                            end
                            default: begin
                                r_res  <= 64'd0;
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    r_cnt <= r_cnt + 7'd1;
                    case (r_op)
                        OP_MUL: begin
                            r_acc <= r_acc + pp_sh;
                            if (r_cnt == 7'd3) begin
                                r_state <= S_FIN;
                            end
                        end
                        OP_DIV: begin
                            r_acc <= r_acc << 1;
                            if (drem >= {1'b0, r_mb}) begin
                                r_rem <= {3'd0, 64'(drem - {1'b0, r_mb})};
                                r_q   <= {r_q[62:0], 1'b1};
                            end else begin
                                r_rem <= {3'd0, drem[63:0]};
                                r_q   <= {r_q[62:0], 1'b0};
                            end
                            if (r_cnt == 7'd63) begin
                                r_state <= S_FIN;
                            end
                        end
                        default: begin
                            r_acc <= r_acc << 2;
                            if (srem >= strial) begin
                                r_rem <= srem - strial;
                                r_q   <= {r_q[62:0], 1'b1};
                            end else begin
                                r_rem <= srem;
                                r_q   <= {r_q[62:0], 1'b0};
                            end
                            if (r_cnt == 7'd63) begin
                                r_state <= S_FIN;
                            end
                        end
                    endcase
                end
                S_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                    case (r_op)
                        OP_MUL: begin
                            if (|mrnd[128:FRAC_BITS + 64]) begin
                                r_res <= r_neg ? S64_MIN : S64_MAX;
                            end else begin
                                r_res <= sat_mag(mrnd[FRAC_BITS + 63:FRAC_BITS], r_neg);
                            end
                        end
                        OP_DIV: begin
                            // round half away from zero
                            if (r_rem[63:0] >= dleft) begin
                                if (&r_q) begin
                                    r_res <= r_neg ? S64_MIN : S64_MAX;
                                end else begin
                                    r_res <= sat_mag(r_q + 64'd1, r_neg);
                                end
                            end else begin
                                r_res <= sat_mag(r_q, r_neg);
                            end
                        end
                        default: r_res <= sat_mag(r_q, 1'b0);
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

>>> sv/rk4_two_body_orbit_step.sv
`default_nettype none
// Two-body orbit stepper, one RK4 step per request, Q16.47 fixed point.
//
// Input stream (s_axis): tuser is the kind, 0 loads position and velocity
// from tdata, 1 advances the held state by one RK4 step of time_step days.
// Output stream (m_axis): every request returns the state after it.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_addr
// (0 sun x, 1 sun y, 2 G*M, 3 time step); write only while idle.
//
// Operation: a load goes to the output stage directly. A step runs a 57-word
// microprogram on one shared arithmetic unit; its four acceleration
// evaluations each need a square root and two divides (64 iterations each),
// and the closing update four more divides. A step's run time is dominated
// by the bit-serial divide/sqrt unit. One request is in flight at a time.
// Reset: planet state cleared, registers to their reset values.
// Stall: the result sits in an output register; a new request is accepted
// while it waits, but its own result is held until the old one is taken.
module rk4_two_body_orbit_step (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // load_pos_x, load_pos_y, load_vel_x, load_vel_y
    input  wire logic [255:0] s_axis_tdata,
    // kind
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pos_x, pos_y, vel_x, vel_y
    output logic [255:0]      m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_addr,
    input  wire logic [63:0]  i_cfg_data
);
    import rk4_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [1:0] CFG_SX = 2'd0;
    localparam logic [1:0] CFG_SY = 2'd1;
    localparam logic [1:0] CFG_GM = 2'd2;
    localparam logic [1:0] CFG_DT = 2'd3;

    logic [2:0]   r_state;
    logic [5:0]   r_pc;
    logic [1:0]   r_stage;
    logic [63:0]  r_px, r_py, r_vx, r_vy;
    logic [63:0]  r_sx, r_sy;
    logic [62:0]  r_gm, r_dt;
    logic [63:0]  r_opa, r_opb;
    logic         r_start;
    logic         r_ovalid;
    logic [255:0] r_odata;
    logic [63:0]  r_mem [16];

    t_uword      w;
    logic        jmp_take;
    logic        fx_done;
    logic [63:0] fx_res;
    logic        accept;
    logic        wr_mem;

    function automatic logic [63:0] reg_val(input logic [4:0] code,
        input logic [63:0] px, input logic [63:0] py,
        input logic [63:0] vx, input logic [63:0] vy,
        input logic [63:0] sx, input logic [63:0] sy,
        input logic [62:0] gm, input logic [62:0] dt, input logic [1:0] stage);
        logic [63:0] v;
        case (code)
            R_PX:    v = px;
            R_PY:    v = py;
            R_VX:    v = vx;
            R_VY:    v = vy;
            R_SX:    v = sx;
            R_SY:    v = sy;
            R_GM:    v = {1'b0, gm};
            R_DT:    v = {1'b0, dt};
            R_H:     v = {2'b0, dt[62:1]};
            R_SIX:   v = SIX_Q;
            // half step for stages 2 and 3, full step for stage 4
            R_STEP:  v = (stage == 2'd2) ? {1'b0, dt} : {2'b0, dt[62:1]};
            default: v = 64'd0;
        endcase
        return v;
    endfunction

    always_comb begin
        w = ucode(r_pc);
        case (w.cond)
            C_FIRST: jmp_take = (r_stage == 2'd0);
            C_LAST:  jmp_take = (r_stage == 2'd3);
            default: jmp_take = 1'b1;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign wr_mem        = (r_state == S_WAIT) && fx_done && w.dst[4];

    rk4_fxu u_fxu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_op     (w.op),
        .i_a      (r_opa),
        .i_b      (r_opb),
        .o_done   (fx_done),
        .o_result (fx_res)
    );

    // scratch RAM: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (wr_mem) begin
            r_mem[w.dst[3:0]] <= fx_res;
        end
        if (r_state == S_FETCH) begin
            r_opa <= w.srca[4] ? r_mem[w.srca[3:0]]
                : reg_val(w.srca, r_px, r_py, r_vx, r_vy, r_sx, r_sy, r_gm, r_dt, r_stage);
            r_opb <= w.srcb[4] ? r_mem[w.srcb[3:0]]
                : reg_val(w.srcb, r_px, r_py, r_vx, r_vy, r_sx, r_sy, r_gm, r_dt, r_stage);
        end
        if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
            r_odata <= {r_vy, r_vx, r_py, r_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= 6'd0;
            r_stage  <= 2'd0;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
            r_px     <= 64'd0;
            r_py     <= 64'd0;
            r_vx     <= 64'd0;
            r_vy     <= 64'd0;
            r_sx     <= 64'd0;
            r_sy     <= 64'd0;
            r_gm     <= GM_RESET;
            r_dt     <= DT_RESET;
        end else begin
            r_start <= 1'b0;
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SX:  r_sx <= i_cfg_data;
                    CFG_SY:  r_sy <= i_cfg_data;
                    CFG_GM:  r_gm <= i_cfg_data[62:0];
                    CFG_DT:  r_dt <= i_cfg_data[62:0];
                    default: r_sx <= r_sx;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!s_axis_tuser) begin
                            r_px    <= s_axis_tdata[63:0];
                            r_py    <= s_axis_tdata[127:64];
                            r_vx    <= s_axis_tdata[191:128];
                            r_vy    <= s_axis_tdata[255:192];
                            r_state <= S_DONE;
                        end else begin
                            r_pc    <= 6'd0;
                            r_stage <= 2'd0;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: r_state <= S_EXEC;
                S_EXEC: begin
                    case (w.op)
                        OP_END: r_state <= S_DONE;
                        OP_JMP: begin
                            r_pc    <= jmp_take ? w.target : r_pc + 6'd1;
                            r_state <= S_FETCH;
                        end
                        OP_LOOP: begin
                            r_stage <= r_stage + 2'd1;
                            r_pc    <= w.target;
                            r_state <= S_FETCH;
                        end
                        default: begin
                            r_start <= 1'b1;
                            r_state <= S_WAIT;
                        end
                    endcase
                end
                S_WAIT: begin
                    if (fx_done) begin
                        if (!w.dst[4]) begin
                            case (w.dst)
                                R_PX:    r_px <= fx_res;
                                R_PY:    r_py <= fx_res;
                                R_VX:    r_vx <= fx_res;
                                R_VY:    r_vy <= fx_res;
                                default: r_px <= r_px;
                            endcase
                        end
                        r_pc    <= r_pc + 6'd1;
                        r_state <= S_FETCH;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule
`default_nettype wire

>>> tb/rk4_two_body_orbit_step_tb.sv
`timescale 1ns / 1ps

module rk4_two_body_orbit_step_tb;
    import rk4_pkg::*;

    // request kinds, carried on s_axis_tuser
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // register indexes
    localparam logic [1:0] CFG_SUN_X = 2'd0;
    localparam logic [1:0] CFG_SUN_Y = 2'd1;
    localparam logic [1:0] CFG_GM    = 2'd2;
    localparam logic [1:0] CFG_DT    = 2'd3;

    localparam logic [63:0] MAG63 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] ONE_AU = 64'sd1 <<< FRAC_BITS;

    // bound for the slowest run, about 1000 requests plus idle gaps
    localparam int CYCLE_LIMIT = 12_000_000;

    // Orbit state predictor plus the queue of expected result words.
    class orbit_scoreboard;
        logic signed [63:0] px, py, vx, vy, sun_x, sun_y;
        logic [62:0] gm, dt;
        logic [255:0] want_q[$];

        function new();
            px = '0; py = '0; vx = '0; vy = '0;
            sun_x = '0; sun_y = '0;
            gm = GM_RESET; dt = DT_RESET;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                CFG_SUN_X: sun_x = val;
                CFG_SUN_Y: sun_y = val;
                CFG_GM:    gm = val[62:0];
                CFG_DT:    dt = val[62:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function logic [63:0] mag(logic signed [63:0] a);
            return a[63] ? 64'(-a) : 64'(a);
        endfunction

        function logic signed [63:0] sat_mag(logic [63:0] m, logic neg);
            if (neg) return (m > MAG63) ? S_MIN : -$signed(m);
            return (m > MAG63) ? S_MAX : $signed(m);
        endfunction

        function logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [64:0] s;
            s = 65'(a) + 65'(b);
            if (s > 65'(S_MAX)) return S_MAX;
            if (s < 65'(S_MIN)) return S_MIN;
            return s[63:0];
        endfunction

        function logic signed [63:0] q_mul(logic signed [63:0] a, logic signed [63:0] b);
            logic [127:0] m;
            m = 128'(mag(a)) * 128'(mag(b)) + (128'd1 << (FRAC_BITS - 1));
            m = m >> FRAC_BITS;
            return sat_mag((m[127:64] != 0) ? '1 : m[63:0], a[63] ^ b[63]);
        endfunction

        function logic signed [63:0] q_div(logic signed [63:0] a, logic signed [63:0] b);
            logic [127:0] num, d, q, r;
            logic neg;
            neg = a[63] ^ b[63];
            if (a == 0) return '0;
            // zero divisor: full scale with the numerator's sign
            if (b == 0) return sat_mag('1, a[63]);
            d = 128'(mag(b));
            num = 128'(mag(a)) << FRAC_BITS;
            if ((num >> 64) >= d) return sat_mag('1, neg);
            q = num / d;
            r = num % d;
            if (r >= d - r) begin
                if (q[63:0] == '1) return sat_mag('1, neg);
                q = q + 128'd1;
            end
            return sat_mag(q[63:0], neg);
        endfunction

        function logic signed [63:0] q_sqrt(logic signed [63:0] v);
            logic [127:0] n, c;
            logic [63:0] res;
            if (v <= 0) return '0;
            n = 128'(v) << FRAC_BITS;
            res = '0;
            for (int bit_i = 63; bit_i >= 0; bit_i--) begin
                c = 128'(res | (64'd1 << bit_i));
                if (c * c <= n) res = c[63:0];
            end
            return sat_mag(res, 1'b0);
        endfunction

        function void accel(input logic signed [63:0] qx, input logic signed [63:0] qy,
                            output logic signed [63:0] ax, output logic signed [63:0] ay);
            logic signed [63:0] dx, dy, r2, r3, g;
            g = $signed({1'b0, gm});
            dx = sub_sat(sun_x, qx);
            dy = sub_sat(sun_y, qy);
            r2 = sat_add(q_mul(dx, dx), q_mul(dy, dy));
            r3 = q_mul(r2, q_sqrt(r2));
            ax = q_div(q_mul(g, dx), r3);
            ay = q_div(q_mul(g, dy), r3);
        endfunction

        function logic signed [63:0] sub_sat(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [64:0] s;
            s = 65'(a) - 65'(b);
            if (s > 65'(S_MAX)) return S_MAX;
            if (s < 65'(S_MIN)) return S_MIN;
            return s[63:0];
        endfunction

        function logic signed [63:0] weigh(logic signed [63:0] k1, logic signed [63:0] k2,
                                           logic signed [63:0] k3, logic signed [63:0] k4);
            logic signed [63:0] s;
            s = sat_add(k1, sat_add(k2, k2));
            s = sat_add(s, sat_add(k3, k3));
            return sat_add(s, k4);
        endfunction

        function void rk_advance();
            logic signed [63:0] t, h, a1x, a1y, a2x, a2y, a3x, a3y, a4x, a4y;
            logic signed [63:0] v2x, v2y, v3x, v3y, v4x, v4y, six;
            t = $signed({1'b0, dt});
            h = $signed({2'b0, dt[62:1]});
            six = SIX_Q;
            accel(px, py, a1x, a1y);
            v2x = sat_add(vx, q_mul(h, a1x));
            v2y = sat_add(vy, q_mul(h, a1y));
            accel(sat_add(px, q_mul(h, vx)), sat_add(py, q_mul(h, vy)), a2x, a2y);
            v3x = sat_add(vx, q_mul(h, a2x));
            v3y = sat_add(vy, q_mul(h, a2y));
            accel(sat_add(px, q_mul(h, v2x)), sat_add(py, q_mul(h, v2y)), a3x, a3y);
            v4x = sat_add(vx, q_mul(t, a3x));
            v4y = sat_add(vy, q_mul(t, a3y));
            accel(sat_add(px, q_mul(t, v3x)), sat_add(py, q_mul(t, v3y)), a4x, a4y);
            px = sat_add(px, q_div(q_mul(t, weigh(vx, v2x, v3x, v4x)), six));
            py = sat_add(py, q_div(q_mul(t, weigh(vy, v2y, v3y, v4y)), six));
            vx = sat_add(vx, q_div(q_mul(t, weigh(a1x, a2x, a3x, a4x)), six));
            vy = sat_add(vy, q_div(q_mul(t, weigh(a1y, a2y, a3y, a4y)), six));
        endfunction

        // accepted request: update the held orbit and queue the state it returns
        function void note_request(logic kind, logic [255:0] data);
            if (kind == KIND_LOAD) begin
                px = data[63:0]; py = data[127:64];
                vx = data[191:128]; vy = data[255:192];
            end else begin
                rk_advance();
            end
            want_q.push_back({vy, vx, py, px});
        endfunction

        // -1 when nothing is waiting, else a mask of the wrong fields
        function int check_result(logic [255:0] got, output logic [255:0] want);
            int bad;
            want = '0;
            if (want_q.size() == 0) return -1;
            want = want_q.pop_front();
            bad = 0;
            for (int f = 0; f < 4; f++)
                if (got[64*f +: 64] !== want[64*f +: 64]) bad |= (1 << f);
            return bad;
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata = '0;   // load_pos_x, load_pos_y, load_vel_x, load_vel_y
    logic         s_axis_tuser = 1'b0; // kind
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [255:0] m_axis_tdata;        // pos_x, pos_y, vel_x, vel_y
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_addr = '0;
    logic [63:0]  i_cfg_data = '0;

    orbit_scoreboard sb = new();
    int  mismatches = 0;
    int  cycles = 0;
    bit  quiet = 0;      // no idling on either side while set
    int  rx_stall = 0;

    rk4_two_body_orbit_step uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // result side: check on every accepted result, then pick next tready
    always @(posedge i_clk) begin
        logic [255:0] want;
        int bad;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            bad = sb.check_result(m_axis_tdata, want);
            if (bad < 0) begin
                report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
            end else begin
                for (int f = 0; f < 4; f++)
                    if (bad[f])
                        report_mismatch($sformatf("field %0d got %h want %h",
                                                  f, m_axis_tdata[64*f +: 64],
                                                  want[64*f +: 64]));
            end
        end
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            rx_stall <= pick_gap();
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one request; tvalid stays up after acceptance so back-to-back needs no dip
    task automatic send_request(logic kind, logic [255:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(kind, data);
    endtask

    task automatic send_load(logic signed [63:0] x, logic signed [63:0] y,
                             logic signed [63:0] vx, logic signed [63:0] vy);
        send_request(KIND_LOAD, {vy, vx, y, x});
    endtask

    // drop tvalid and hold off until every expected result has arrived
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // write all four registers on consecutive cycles; block must be idle
    task automatic write_regs(logic [63:0] sx, logic [63:0] sy,
                              logic [63:0] g, logic [63:0] t);
        logic [63:0] vals[4];
        vals = '{sx, sy, g, t};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= 2'(i);
            i_cfg_data <= vals[i];
            sb.set_reg(2'(i), vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // scaled random value, a shift drawn from lo to hi picks the magnitude
    function automatic logic signed [63:0] rnd_q(int lo, int hi);
        logic signed [63:0] v;
        v = $signed(rnd64());
        return v >>> $urandom_range(lo, hi);
    endfunction

    task automatic random_phase(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                send_request(KIND_STEP, 256'(rnd64()));   // tdata ignored on a step
            else if (r < 85)
                send_load(rnd_q(13, 20), rnd_q(13, 20), rnd_q(20, 27), rnd_q(20, 27));
            else
                send_load(rnd64(), rnd64(), rnd64(), rnd64());
            if ($urandom_range(0, 39) == 0) drain();
            if ($urandom_range(0, 29) == 0) quiet = ~quiet;
        end
        quiet = 0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset registers; state at the sun gives r3 = 0
        send_request(KIND_STEP, '0);
        send_load(ONE_AU, 64'sd0, 64'sd0, 64'sd2420684799711);
        repeat (4) send_request(KIND_STEP, '1);
        send_load(S_MAX, S_MAX, S_MAX, S_MAX);
        send_request(KIND_STEP, '0);
        send_load(S_MIN, S_MIN, S_MIN, S_MIN);
        send_request(KIND_STEP, '0);
        send_load(S_MAX, S_MIN, S_MIN, S_MAX);
        send_request(KIND_STEP, '0);
        send_load(64'sd0, -ONE_AU, -64'sd2420684799711, 64'sd0);
        send_request(KIND_STEP, '0);
        send_load(64'sd1, -64'sd1, 64'sd1, -64'sd1);
        send_request(KIND_STEP, '0);
        drain();

        // extremes of the registers: zero and full-scale G*M and dt, offset sun
        write_regs(S_MAX, S_MIN, 64'h0, {1'b1, MAG63[62:0]});
        send_load(64'sd0, 64'sd0, ONE_AU, ONE_AU);
        send_request(KIND_STEP, '0);
        send_load(S_MIN, S_MAX, 64'sd0, 64'sd0);
        send_request(KIND_STEP, '0);
        drain();
        write_regs(S_MIN, S_MAX, MAG63, 64'h0);
        send_load(ONE_AU, ONE_AU, ONE_AU, 64'sd0);
        send_request(KIND_STEP, '0);
        send_load(S_MIN, S_MAX, 64'sd0, 64'sd0);
        send_request(KIND_STEP, '0);
        drain();

        // random phases, mix of realistic and random settings
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: write_regs(64'd0, 64'd0, 64'(GM_RESET), 64'(DT_RESET));
                1: write_regs(rnd_q(14, 20), rnd_q(14, 20),
                              64'(GM_RESET) << $urandom_range(0, 8),
                              64'(DT_RESET) << $urandom_range(0, 6));
                2: write_regs(rnd64(), rnd64(), rnd64(), rnd64());
                default: write_regs(rnd_q(16, 22), rnd_q(16, 22),
                                    rnd64() >> $urandom_range(20, 40),
                                    rnd64() >> $urandom_range(16, 30));
            endcase
            random_phase(120);
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
